>>> sv/sse_pkg.sv
// shared constants and types for the stack expression evaluator
// no dependencies; used by sse_div and stack_expression_evaluator
package sse_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int VALUE_WIDTH = 16;

    localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CW  = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [PTR_W-1:0]       t_ptr;
    typedef logic [DIV_CW-1:0]      t_div_cnt;

    localparam t_cnt DEPTH_CNT = t_cnt'(STACK_DEPTH);

    // token codes
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;

    // stand-in operand for an empty pop: '1' minus '0'
    localparam t_val UNF_VALUE = t_val'(int'(CH_ONE) - int'(CH_ZERO));

    // sticky flag bit positions
    localparam int FLAG_OVF = 0;
    localparam int FLAG_UNF = 1;
    localparam int FLAG_DIV = 2;

endpackage

>>> sv/sse_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on sse_pkg; zero divisor is handled by the caller
module sse_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sse_pkg::t_val i_dividend,
    input  sse_pkg::t_val i_divisor,
    output logic          o_done,
    output sse_pkg::t_val o_quot
);

    localparam int VW = sse_pkg::VALUE_WIDTH;

    logic              r_busy;
    logic              r_done;
    sse_pkg::t_div_cnt r_cnt;
    sse_pkg::t_val     r_quo;
    sse_pkg::t_val     r_rem;
    sse_pkg::t_val     r_dsr;
    logic              r_neg;

    sse_pkg::t_val     w_abs_dvd;
    sse_pkg::t_val     w_abs_dsr;
    logic [VW:0]       w_sh;
    logic [VW:0]       w_diff;
    logic              w_fit;

    assign w_abs_dvd = i_dividend[VW-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_abs_dsr = i_divisor[VW-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    assign w_sh   = {r_rem, r_quo[VW-1]};
    assign w_diff = w_sh - {1'b0, r_dsr};
    assign w_fit  = (w_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == sse_pkg::t_div_cnt'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sse_pkg::t_div_cnt'(VW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == sse_pkg::t_div_cnt'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_abs_dvd;
            r_rem <= '0;
            r_dsr <= w_abs_dsr;
            r_neg <= i_dividend[VW-1] ^ i_divisor[VW-1];
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= w_diff[VW-1:0];
                r_quo <= {r_quo[VW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[VW-1:0];
                r_quo <= {r_quo[VW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

>>> sv/stack_expression_evaluator.sv
// postfix expression evaluator over a value stack held in a synchronous ram
// depends on sse_pkg and sse_div
//
// Input channel: i_valid / o_stall carry one token (i_token_char, i_last) per
// transfer. Digits and other characters push their code minus '0'; '+', '-',
// '*', '/' pop the top (first) and the one below (second) and push first op
// second. A token with i_last set produces one output transfer on
// o_valid / i_stall: the last operator result (0 if none) with sticky
// overflow, underflow and divide-by-zero flags; the block then clears.
// One token at a time: o_stall stays high from acceptance until the token
// finishes. A value token is decoded and pushed; +, -, * go through two
// registered stack ram reads, then execute and write back; / also runs the
// bit-serial divider between execute and write back, unless the divisor is
// zero. A last token adds a step that loads the output register. The output
// register lets the block take new tokens while a result waits; if the
// receiver stalls when the next last token finishes, the block holds in that
// step until the register frees up.
// Reset (synchronous, active low) empties the stack and clears the last
// result, flags and output valid; stack ram contents are not cleared.
module stack_expression_evaluator (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [7:0]                              i_token_char,
    input  logic                                    i_last,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [sse_pkg::VALUE_WIDTH-1:0] o_value,
    output logic                                    o_overflow_seen,
    output logic                                    o_underflow_seen,
    output logic                                    o_divide_by_zero_seen
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_RD1    = 3'd2;
    localparam logic [2:0] ST_RD2    = 3'd3;
    localparam logic [2:0] ST_EXEC   = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_PUSH   = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    // stack ram
    sse_pkg::t_val mem [sse_pkg::STACK_DEPTH];
    sse_pkg::t_val r_rdata;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [7:0]    r_tok;
    logic          r_last;
    sse_pkg::t_cnt r_cnt;
    sse_pkg::t_val r_last_res;
    logic [2:0]    r_flags;
    logic          r_a_ok;
    logic          r_b_ok;
    sse_pkg::t_val r_op_a;
    sse_pkg::t_val r_op_b;
    sse_pkg::t_val r_res;

    logic          r_out_valid;
    sse_pkg::t_val r_out_value;
    logic [2:0]    r_out_flags;

    logic          w_is_op;
    sse_pkg::t_val w_tok_val;
    sse_pkg::t_cnt w_cnt_m1;
    sse_pkg::t_cnt w_cnt_m2;
    sse_pkg::t_ptr w_raddr;
    logic          w_push_step;
    logic          w_room;
    logic          w_we;
    sse_pkg::t_val w_wdata;
    logic          w_out_free;
    logic          w_div_start;
    logic          w_div_done;
    sse_pkg::t_val w_div_quot;

    assign w_is_op = (r_tok == sse_pkg::CH_ADD) || (r_tok == sse_pkg::CH_SUB) ||
                     (r_tok == sse_pkg::CH_MUL) || (r_tok == sse_pkg::CH_DIV);
    assign w_tok_val = sse_pkg::t_val'(int'(r_tok) - int'(sse_pkg::CH_ZERO));

    assign w_cnt_m1 = r_cnt - sse_pkg::t_cnt'(1);
    assign w_cnt_m2 = r_cnt - sse_pkg::t_cnt'(2);
    assign w_raddr  = (r_state == ST_RD1) ? w_cnt_m2[sse_pkg::PTR_W-1:0]
                                          : w_cnt_m1[sse_pkg::PTR_W-1:0];

    assign w_push_step = ((r_state == ST_DECODE) && !w_is_op) || (r_state == ST_PUSH);
    assign w_room      = (r_cnt < sse_pkg::DEPTH_CNT);
    assign w_we        = w_push_step && w_room;
    assign w_wdata     = (r_state == ST_PUSH) ? r_res : w_tok_val;

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_div_start = (r_state == ST_EXEC) && (r_tok == sse_pkg::CH_DIV) &&
                         (r_op_b != '0);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_cnt[sse_pkg::PTR_W-1:0]] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    sse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_op_a),
        .i_divisor  (r_op_b),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                if (w_is_op) n_state = ST_RD1;
                else         n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_RD1:    n_state = ST_RD2;
            ST_RD2:    n_state = ST_EXEC;
            ST_EXEC:   n_state = w_div_start ? ST_DIV : ST_PUSH;
            ST_DIV:    if (w_div_done) n_state = ST_PUSH;
            ST_PUSH:   n_state = r_last ? ST_FIN : ST_IDLE;
            ST_FIN:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_last_res  <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FIN) && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)      r_out_valid <= 1'b0;
            case (r_state)
                ST_DECODE, ST_PUSH: begin
                    if (w_push_step) begin
                        if (w_room) r_cnt <= r_cnt + 1'b1;
                        else        r_flags[sse_pkg::FLAG_OVF] <= 1'b1;
                    end
                    if (r_state == ST_PUSH) r_last_res <= r_res;
                end
                ST_RD2: begin
                    r_cnt <= r_cnt - sse_pkg::t_cnt'(r_a_ok) - sse_pkg::t_cnt'(r_b_ok);
                    if (!r_b_ok) r_flags[sse_pkg::FLAG_UNF] <= 1'b1;
                end
                ST_EXEC: begin
                    if ((r_tok == sse_pkg::CH_DIV) && (r_op_b == '0))
                        r_flags[sse_pkg::FLAG_DIV] <= 1'b1;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_cnt       <= '0;
                        r_last_res  <= '0;
                        r_flags     <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_valid) begin
            r_tok  <= i_token_char;
            r_last <= i_last;
        end
        if (r_state == ST_DECODE) r_a_ok <= (r_cnt != '0);
        if (r_state == ST_RD1) begin
            r_b_ok <= (r_cnt >= sse_pkg::t_cnt'(2));
            r_op_a <= r_a_ok ? r_rdata : sse_pkg::UNF_VALUE;
        end
        if (r_state == ST_RD2) r_op_b <= r_b_ok ? r_rdata : sse_pkg::UNF_VALUE;
        if (r_state == ST_EXEC) begin
            case (r_tok)
                sse_pkg::CH_ADD: r_res <= r_op_a + r_op_b;
                sse_pkg::CH_SUB: r_res <= r_op_a - r_op_b;
                sse_pkg::CH_MUL: r_res <= sse_pkg::t_val'(r_op_a * r_op_b);
                default:         r_res <= '0;
            endcase
        end
        if ((r_state == ST_DIV) && w_div_done) r_res <= w_div_quot;
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_value <= r_last_res;
            r_out_flags <= r_flags;
        end
    end

    assign o_stall               = (r_state != ST_IDLE);
    assign o_valid               = r_out_valid;
    assign o_value               = r_out_value;
    assign o_overflow_seen       = r_out_flags[sse_pkg::FLAG_OVF];
    assign o_underflow_seen      = r_out_flags[sse_pkg::FLAG_UNF];
    assign o_divide_by_zero_seen = r_out_flags[sse_pkg::FLAG_DIV];

endmodule
